// ----- src/ldp_pkg.sv -----
// Shared types and constants for the lens distortion projector.
`default_nettype none

package ldp_pkg;

    // Field and port widths
    localparam int CFG_DW = 40;
    localparam int IDX_W  = 3;
    localparam int XW     = 18;
    localparam int PIXW   = 22;
    localparam int COEF_W = 24;
    localparam int PIXF_W = 20;
    localparam int SKEW_W = 22;
    localparam int S_W    = 40;
    localparam int T_W    = 35;

    // Output clamp limits, signed Q14.8
    localparam logic signed [PIXW-1:0] OUT_MAX = 22'sh1FFFFF;
    localparam logic signed [PIXW-1:0] OUT_MIN = 22'sh200000;

    // Configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_K1     = 3'd0,
        REG_K2     = 3'd1,
        REG_K3     = 3'd2,
        REG_P1     = 3'd3,
        REG_P2     = 3'd4,
        REG_FOCAL  = 3'd5,
        REG_CENTER = 3'd6,
        REG_SKEW   = 3'd7
    } t_reg_idx;

    // Lens and camera settings as seen by the datapath
    typedef struct packed {
        logic [COEF_W-1:0] k1;
        logic [COEF_W-1:0] k2;
        logic [COEF_W-1:0] k3;
        logic [COEF_W-1:0] p1;
        logic [COEF_W-1:0] p2;
        logic [PIXF_W-1:0] fx;
        logic [PIXF_W-1:0] fy;
        logic [PIXF_W-1:0] cx;
        logic [PIXF_W-1:0] cy;
        logic [SKEW_W-1:0] alpha;
    } t_cfg;

    // Word handed from the distortion polynomial to the projection stages
    typedef struct packed {
        logic           valid;
        logic [XW-1:0]  x;
        logic [XW-1:0]  y;
        logic [S_W-1:0] s;
        logic [T_W-1:0] tx;
        logic [T_W-1:0] ty;
    } t_poly;

endpackage

`default_nettype wire

// ----- src/lens_distort_project.sv -----
// Top level of the lens distortion projector: settings registers and pipeline.
//
// Maps one normalized point (x_norm, y_norm, signed Q2.16) per clock to distorted
// pixel coordinates (signed Q14.8) with radial, tangential, skew, focal and center
// terms. A word is taken at every edge where start is high; busy stays low, so a
// new point may enter every cycle. Each result appears on o_pixel_x, o_pixel_y and
// o_saturated for exactly one cycle with o_valid high, after eight stages for the
// distortion polynomial and six for projection and clamping. The receiver cannot
// stall the pipeline and must take every word as it comes. Write the settings only
// while no point is in flight.
`default_nettype none

module lens_distort_project (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ldp_pkg::XW-1:0]         i_x_norm,
    input  logic signed [ldp_pkg::XW-1:0]         i_y_norm,
    input  logic                                  i_cfg_we,
    input  logic [ldp_pkg::IDX_W-1:0]             i_cfg_index,
    input  logic [ldp_pkg::CFG_DW-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic signed [ldp_pkg::PIXW-1:0]       o_pixel_x,
    output logic signed [ldp_pkg::PIXW-1:0]       o_pixel_y,
    output logic                                  o_saturated
);

    localparam int COEF_W = ldp_pkg::COEF_W;
    localparam int PIXF_W = ldp_pkg::PIXF_W;

    logic [COEF_W-1:0]          r_k1, r_k2, r_k3, r_p1, r_p2;
    logic [2*PIXF_W-1:0]        r_focal, r_center;
    logic [ldp_pkg::SKEW_W-1:0] r_skew;
    ldp_pkg::t_cfg              cfg;
    ldp_pkg::t_poly             poly;
    ldp_pkg::t_reg_idx          cfg_idx;

    // The pipeline never holds off a new word
    assign busy = 1'b0;

    assign cfg_idx = ldp_pkg::t_reg_idx'(i_cfg_index);

    // Decode settings writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1     <= '0;
            r_k2     <= '0;
            r_k3     <= '0;
            r_p1     <= '0;
            r_p2     <= '0;
            r_focal  <= '0;
            r_center <= '0;
            r_skew   <= '0;
        end else if (i_cfg_we) begin
            unique case (cfg_idx)
                ldp_pkg::REG_K1:     r_k1     <= i_cfg_data[COEF_W-1:0];
                ldp_pkg::REG_K2:     r_k2     <= i_cfg_data[COEF_W-1:0];
                ldp_pkg::REG_K3:     r_k3     <= i_cfg_data[COEF_W-1:0];
                ldp_pkg::REG_P1:     r_p1     <= i_cfg_data[COEF_W-1:0];
                ldp_pkg::REG_P2:     r_p2     <= i_cfg_data[COEF_W-1:0];
                ldp_pkg::REG_FOCAL:  r_focal  <= i_cfg_data[2*PIXF_W-1:0];
                ldp_pkg::REG_CENTER: r_center <= i_cfg_data[2*PIXF_W-1:0];
                ldp_pkg::REG_SKEW:   r_skew   <= i_cfg_data[ldp_pkg::SKEW_W-1:0];
                default: ;
            endcase
        end
    end

    // Gather settings for the datapath
    assign cfg.k1    = r_k1;
    assign cfg.k2    = r_k2;
    assign cfg.k3    = r_k3;
    assign cfg.p1    = r_p1;
    assign cfg.p2    = r_p2;
    assign cfg.fx    = r_focal[PIXF_W-1:0];
    assign cfg.fy    = r_focal[2*PIXF_W-1:PIXF_W];
    assign cfg.cx    = r_center[PIXF_W-1:0];
    assign cfg.cy    = r_center[2*PIXF_W-1:PIXF_W];
    assign cfg.alpha = r_skew;

    ldp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_x     (i_x_norm),
        .i_y     (i_y_norm),
        .i_cfg   (cfg),
        .o_poly  (poly)
    );

    ldp_proj u_proj (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_poly      (poly),
        .i_cfg       (cfg),
        .o_valid     (o_valid),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_saturated (o_saturated)
    );

endmodule

`default_nettype wire

// ----- src/ldp_poly.sv -----
// Radial scale and tangential shift pipeline, eight register stages.
`default_nettype none

module ldp_poly (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic signed [ldp_pkg::XW-1:0]      i_x,
    input  logic signed [ldp_pkg::XW-1:0]      i_y,
    input  ldp_pkg::t_cfg                      i_cfg,
    output ldp_pkg::t_poly                     o_poly
);

    localparam int XW = ldp_pkg::XW;

    // Signed views of the coefficients
    logic signed [ldp_pkg::COEF_W-1:0] k1, k2, k3, p1, p2;
    assign k1 = i_cfg.k1;
    assign k2 = i_cfg.k2;
    assign k3 = i_cfg.k3;
    assign p1 = i_cfg.p1;
    assign p2 = i_cfg.p2;

    logic [7:0] r_vld, n_vld;

    // Stage 1: squares and cross product, exact Q.32
    logic signed [XW-1:0] r_x1, r_y1;
    logic signed [35:0]   r_xx1, r_yy1, r_xy1, n_xx1, n_yy1, n_xy1;
    // Stage 2: r2 rounded to Q.24 and tangential sums
    logic signed [XW-1:0] r_x2, r_y2;
    logic signed [35:0]   r_xy2;
    logic signed [36:0]   n_r2, n_r2t;
    logic signed [28:0]   r_r2q2, n_r2q2;
    logic signed [37:0]   r_sx2, r_sy2, n_sx2, n_sy2;
    // Stage 3: products
    logic signed [XW-1:0] r_x3, r_y3;
    logic signed [28:0]   r_r2q3;
    logic signed [57:0]   r_r2sq3, n_r2sq3;
    logic signed [52:0]   r_k1r3, n_k1r3;
    logic signed [59:0]   r_p1xy3, r_p2xy3, n_p1xy3, n_p2xy3;
    logic signed [61:0]   r_p2sx3, r_p1sy3, n_p2sx3, n_p1sy3;
    // Stage 4: r4 and tangential terms rounded to Q.24
    logic signed [XW-1:0] r_x4, r_y4;
    logic signed [28:0]   r_r2q4;
    logic signed [52:0]   r_k1r4;
    logic signed [57:0]   n_r4t;
    logic signed [31:0]   r_r44, n_r44;
    logic signed [62:0]   n_txt, n_tyt;
    logic signed [ldp_pkg::T_W-1:0] r_tx4, r_ty4, n_tx4, n_ty4;
    // Stage 5: r4*r2 and k2*r4
    logic signed [XW-1:0] r_x5, r_y5;
    logic signed [52:0]   r_k1r5;
    logic signed [60:0]   r_r4r25, n_r4r25;
    logic signed [55:0]   r_k2r45, n_k2r45;
    logic signed [ldp_pkg::T_W-1:0] r_tx5, r_ty5;
    // Stage 6: r6 and partial scale sum
    logic signed [XW-1:0] r_x6, r_y6;
    logic signed [60:0]   n_r6t;
    logic signed [34:0]   r_r66, n_r66;
    logic signed [59:0]   r_acc6, n_acc6;
    logic signed [ldp_pkg::T_W-1:0] r_tx6, r_ty6;
    // Stage 7: k3*r6
    logic signed [XW-1:0] r_x7, r_y7;
    logic signed [59:0]   r_acc7;
    logic signed [58:0]   r_k3r67, n_k3r67;
    logic signed [ldp_pkg::T_W-1:0] r_tx7, r_ty7;
    // Stage 8: scale rounded to Q.24
    logic signed [XW-1:0] r_x8, r_y8;
    logic signed [59:0]   n_st;
    logic signed [ldp_pkg::S_W-1:0] r_s8, n_s8;
    logic signed [ldp_pkg::T_W-1:0] r_tx8, r_ty8;

    assign n_vld = {r_vld[6:0], i_valid};

    // Stage 1 logic
    assign n_xx1 = i_x * i_x;
    assign n_yy1 = i_y * i_y;
    assign n_xy1 = i_x * i_y;

    // Stage 2 logic
    assign n_r2  = 37'(r_xx1) + 37'(r_yy1);
    assign n_r2t = n_r2 + 37'sd128;
    assign n_r2q2 = n_r2t[36:8];
    assign n_sx2 = 38'(n_r2) + (38'(r_xx1) <<< 1);
    assign n_sy2 = 38'(n_r2) + (38'(r_yy1) <<< 1);

    // Stage 3 logic
    assign n_r2sq3 = r_r2q2 * r_r2q2;
    assign n_k1r3  = k1 * r_r2q2;
    assign n_p1xy3 = p1 * r_xy2;
    assign n_p2xy3 = p2 * r_xy2;
    assign n_p2sx3 = p2 * r_sx2;
    assign n_p1sy3 = p1 * r_sy2;

    // Stage 4 logic
    assign n_r4t = r_r2sq3 + 58'sd8388608;
    assign n_r44 = n_r4t[55:24];
    assign n_txt = (63'(r_p1xy3) <<< 1) + 63'(r_p2sx3) + 63'sd134217728;
    assign n_tyt = 63'(r_p1sy3) + (63'(r_p2xy3) <<< 1) + 63'sd134217728;
    assign n_tx4 = n_txt[62:28];
    assign n_ty4 = n_tyt[62:28];

    // Stage 5 logic
    assign n_r4r25 = r_r44 * r_r2q4;
    assign n_k2r45 = k2 * r_r44;

    // Stage 6 logic
    assign n_r6t  = r_r4r25 + 61'sd8388608;
    assign n_r66  = n_r6t[58:24];
    assign n_acc6 = {15'd0, 1'b1, 44'd0} + 60'(r_k1r5) + 60'(r_k2r45);

    // Stage 7 logic
    assign n_k3r67 = k3 * r_r66;

    // Stage 8 logic
    assign n_st = r_acc7 + 60'(r_k3r67) + 60'sd524288;
    assign n_s8 = n_st[59:20];

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Advance the datapath words
    always_ff @(posedge i_clk) begin
        r_x1    <= i_x;
        r_y1    <= i_y;
        r_xx1   <= n_xx1;
        r_yy1   <= n_yy1;
        r_xy1   <= n_xy1;

        r_x2    <= r_x1;
        r_y2    <= r_y1;
        r_xy2   <= r_xy1;
        r_r2q2  <= n_r2q2;
        r_sx2   <= n_sx2;
        r_sy2   <= n_sy2;

        r_x3    <= r_x2;
        r_y3    <= r_y2;
        r_r2q3  <= r_r2q2;
        r_r2sq3 <= n_r2sq3;
        r_k1r3  <= n_k1r3;
        r_p1xy3 <= n_p1xy3;
        r_p2xy3 <= n_p2xy3;
        r_p2sx3 <= n_p2sx3;
        r_p1sy3 <= n_p1sy3;

        r_x4    <= r_x3;
        r_y4    <= r_y3;
        r_r2q4  <= r_r2q3;
        r_k1r4  <= r_k1r3;
        r_r44   <= n_r44;
        r_tx4   <= n_tx4;
        r_ty4   <= n_ty4;

        r_x5    <= r_x4;
        r_y5    <= r_y4;
        r_k1r5  <= r_k1r4;
        r_r4r25 <= n_r4r25;
        r_k2r45 <= n_k2r45;
        r_tx5   <= r_tx4;
        r_ty5   <= r_ty4;

        r_x6    <= r_x5;
        r_y6    <= r_y5;
        r_r66   <= n_r66;
        r_acc6  <= n_acc6;
        r_tx6   <= r_tx5;
        r_ty6   <= r_ty5;

        r_x7    <= r_x6;
        r_y7    <= r_y6;
        r_acc7  <= r_acc6;
        r_k3r67 <= n_k3r67;
        r_tx7   <= r_tx6;
        r_ty7   <= r_ty6;

        r_x8    <= r_x7;
        r_y8    <= r_y7;
        r_s8    <= n_s8;
        r_tx8   <= r_tx7;
        r_ty8   <= r_ty7;
    end

    // Hand the scale and shifts to the projection stages
    assign o_poly.valid = r_vld[7];
    assign o_poly.x     = r_x8;
    assign o_poly.y     = r_y8;
    assign o_poly.s     = r_s8;
    assign o_poly.tx    = r_tx8;
    assign o_poly.ty    = r_ty8;

endmodule

`default_nettype wire

// ----- src/ldp_proj.sv -----
// Distorted point, skew, focal scaling, centering and clamp, six register stages.
`default_nettype none

module ldp_proj (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ldp_pkg::t_poly                       i_poly,
    input  ldp_pkg::t_cfg                        i_cfg,
    output logic                                 o_valid,
    output logic signed [ldp_pkg::PIXW-1:0]      o_pixel_x,
    output logic signed [ldp_pkg::PIXW-1:0]      o_pixel_y,
    output logic                                 o_saturated
);

    localparam int PIXW = ldp_pkg::PIXW;

    // Signed views of the incoming word and settings
    logic signed [ldp_pkg::XW-1:0]     x, y;
    logic signed [ldp_pkg::S_W-1:0]    s;
    logic signed [ldp_pkg::T_W-1:0]    tx, ty;
    logic signed [ldp_pkg::SKEW_W-1:0] alpha;
    logic signed [ldp_pkg::PIXF_W:0]   fxs, fys;

    assign x     = i_poly.x;
    assign y     = i_poly.y;
    assign s     = i_poly.s;
    assign tx    = i_poly.tx;
    assign ty    = i_poly.ty;
    assign alpha = i_cfg.alpha;
    assign fxs   = {1'b0, i_cfg.fx};
    assign fys   = {1'b0, i_cfg.fy};

    logic [5:0] r_vld, n_vld;

    // Stage 1: scale times point
    logic signed [57:0] r_sx1, r_sy1, n_sx1, n_sy1;
    logic signed [ldp_pkg::T_W-1:0] r_tx1, r_ty1;
    // Stage 2: distorted point in Q.24
    logic signed [57:0] n_xdt, n_ydt;
    logic signed [41:0] r_xd2, r_yd2, n_xd2, n_yd2;
    // Stage 3: skew product
    logic signed [41:0] r_xd3, r_yd3;
    logic signed [63:0] r_ayd3, n_ayd3;
    // Stage 4: skewed x
    logic signed [63:0] n_aydt;
    logic signed [43:0] r_u4, n_u4;
    logic signed [41:0] r_yd4;
    // Stage 5: focal products
    logic signed [64:0] r_fxu5, n_fxu5;
    logic signed [62:0] r_fyyd5, n_fyyd5;
    // Stage 6: center, round to Q.8, clamp
    logic signed [64:0] n_vx, n_vy;
    logic signed [40:0] n_px, n_py;
    logic signed [PIXW-1:0] r_pixel_x, r_pixel_y, n_pixel_x, n_pixel_y;
    logic r_saturated, n_saturated;
    logic sat_x, sat_y;

    assign n_vld = {r_vld[4:0], i_poly.valid};

    assign n_sx1 = s * x;
    assign n_sy1 = s * y;

    assign n_xdt = r_sx1 + 58'sd32768;
    assign n_ydt = r_sy1 + 58'sd32768;
    assign n_xd2 = n_xdt[57:16] + 42'(r_tx1);
    assign n_yd2 = n_ydt[57:16] + 42'(r_ty1);

    assign n_ayd3 = alpha * r_yd2;

    assign n_aydt = r_ayd3 + 64'sd524288;
    assign n_u4   = 44'(r_xd3) + n_aydt[63:20];

    assign n_fxu5  = fxs * r_u4;
    assign n_fyyd5 = fys * r_yd4;

    assign n_vx = r_fxu5 + 65'({i_cfg.cx, 24'd0}) + 65'sd8388608;
    assign n_vy = 65'(r_fyyd5) + 65'({i_cfg.cy, 24'd0}) + 65'sd8388608;
    assign n_px = n_vx[64:24];
    assign n_py = n_vy[64:24];

    // Clamp each coordinate to the signed Q14.8 range
    always_comb begin
        sat_x     = 1'b0;
        sat_y     = 1'b0;
        n_pixel_x = n_px[PIXW-1:0];
        n_pixel_y = n_py[PIXW-1:0];
        if (n_px > 41'(ldp_pkg::OUT_MAX)) begin
            n_pixel_x = ldp_pkg::OUT_MAX;
            sat_x     = 1'b1;
        end else if (n_px < 41'(ldp_pkg::OUT_MIN)) begin
            n_pixel_x = ldp_pkg::OUT_MIN;
            sat_x     = 1'b1;
        end
        if (n_py > 41'(ldp_pkg::OUT_MAX)) begin
            n_pixel_y = ldp_pkg::OUT_MAX;
            sat_y     = 1'b1;
        end else if (n_py < 41'(ldp_pkg::OUT_MIN)) begin
            n_pixel_y = ldp_pkg::OUT_MIN;
            sat_y     = 1'b1;
        end
        n_saturated = sat_x | sat_y;
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Advance the datapath words
    always_ff @(posedge i_clk) begin
        r_sx1       <= n_sx1;
        r_sy1       <= n_sy1;
        r_tx1       <= tx;
        r_ty1       <= ty;

        r_xd2       <= n_xd2;
        r_yd2       <= n_yd2;

        r_xd3       <= r_xd2;
        r_yd3       <= r_yd2;
        r_ayd3      <= n_ayd3;

        r_u4        <= n_u4;
        r_yd4       <= r_yd3;

        r_fxu5      <= n_fxu5;
        r_fyyd5     <= n_fyyd5;

        r_pixel_x   <= n_pixel_x;
        r_pixel_y   <= n_pixel_y;
        r_saturated <= n_saturated;
    end

    assign o_valid     = r_vld[5];
    assign o_pixel_x   = r_pixel_x;
    assign o_pixel_y   = r_pixel_y;
    assign o_saturated = r_saturated;

endmodule

`default_nettype wire

// ----- bench/pixel_checker.sv -----
// Scoreboard for the lens distortion projector: predicts every pixel word and checks results.
module pixel_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic signed [ldp_pkg::XW-1:0]    i_x_norm,
    input  logic signed [ldp_pkg::XW-1:0]    i_y_norm,
    input  logic                             i_cfg_we,
    input  logic [ldp_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [ldp_pkg::CFG_DW-1:0]       i_cfg_data,
    input  logic                             i_valid,
    input  logic signed [ldp_pkg::PIXW-1:0]  i_pixel_x,
    input  logic signed [ldp_pkg::PIXW-1:0]  i_pixel_y,
    input  logic                             i_saturated,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_clamped
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [ldp_pkg::PIXW-1:0] px;
        logic signed [ldp_pkg::PIXW-1:0] py;
        logic                            sat;
    } t_pixel_word;

    // Shadow copy of the lens and camera settings
    logic signed [ldp_pkg::COEF_W-1:0] k1, k2, k3, p1, p2;
    logic        [ldp_pkg::PIXF_W-1:0] fx, fy, cx, cy;
    logic signed [ldp_pkg::SKEW_W-1:0] alpha;

    t_pixel_word expected_pixels[$];

    // Round half up: add half an LSB of the target, then floor
    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    // Distort one normalized point and project it to saturated pixel coordinates
    function automatic t_pixel_word project_point(logic signed [ldp_pkg::XW-1:0] x_in,
                                                  logic signed [ldp_pkg::XW-1:0] y_in);
        longint x, y, xx, yy, xy, r2, r2q, r4, r6, s, tx, ty, xd, yd, u, px, py;
        longint out_hi, out_lo;
        t_pixel_word w;
        x = x_in;
        y = y_in;
        out_hi = longint'(ldp_pkg::OUT_MAX);
        out_lo = longint'(ldp_pkg::OUT_MIN);
        // Radius powers, all kept at Q.24 after the first square
        xx  = x * x;
        yy  = y * y;
        xy  = x * y;
        r2  = xx + yy;
        r2q = round_shift(r2, 8);
        r4  = round_shift(r2q * r2q, 24);
        r6  = round_shift(r4 * r2q, 24);
        s   = round_shift((longint'(1) <<< 44) + longint'(k1) * r2q + longint'(k2) * r4
                          + longint'(k3) * r6, 20);
        // Tangential shift from the exact products
        tx  = round_shift(2 * longint'(p1) * xy + longint'(p2) * (r2 + 2 * xx), 28);
        ty  = round_shift(longint'(p1) * (r2 + 2 * yy) + 2 * longint'(p2) * xy, 28);
        xd  = round_shift(s * x, 16) + tx;
        yd  = round_shift(s * y, 16) + ty;
        // Skew, focal lengths and principal point
        u   = xd + round_shift(longint'(alpha) * yd, 20);
        px  = round_shift(longint'(fx) * u + (longint'(cx) <<< 24), 24);
        py  = round_shift(longint'(fy) * yd + (longint'(cy) <<< 24), 24);
        w.sat = 1'b0;
        if (px > out_hi) begin
            px = out_hi;
            w.sat = 1'b1;
        end else if (px < out_lo) begin
            px = out_lo;
            w.sat = 1'b1;
        end
        if (py > out_hi) begin
            py = out_hi;
            w.sat = 1'b1;
        end else if (py < out_lo) begin
            py = out_lo;
            w.sat = 1'b1;
        end
        w.px = px[ldp_pkg::PIXW-1:0];
        w.py = py[ldp_pkg::PIXW-1:0];
        return w;
    endfunction

    // Check results, queue predictions, then track settings writes
    always @(posedge i_clk) begin
        t_pixel_word seen, want;
        if (!i_rst_n) begin
            k1 = '0; k2 = '0; k3 = '0; p1 = '0; p2 = '0;
            fx = '0; fy = '0; cx = '0; cy = '0;
            alpha = '0;
            expected_pixels.delete();
        end else begin
            // Compare the result word against the oldest prediction
            if (i_valid === 1'b1) begin
                seen = {i_pixel_x, i_pixel_y, i_saturated};
                if (i_saturated === 1'b1)
                    o_clamped++;
                if (expected_pixels.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("%0t: result with no point in flight: x=%0d y=%0d sat=%0b",
                                 $time, seen.px, seen.py, seen.sat);
                end else begin
                    want = expected_pixels.pop_front();
                    o_checked++;
                    if (seen !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT)
                            $display("%0t: pixel mismatch: expected x=%0d y=%0d sat=%0b, %s",
                                     $time, want.px, want.py, want.sat,
                                     $sformatf("got x=%0d y=%0d sat=%0b",
                                               seen.px, seen.py, seen.sat));
                    end
                end
            end
            // Predict every accepted point with the settings in force
            if (i_start === 1'b1 && i_busy === 1'b0)
                expected_pixels.push_back(project_point(i_x_norm, i_y_norm));
            // Follow register writes, dropping bits above each field
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_index)
                    ldp_pkg::REG_K1:     k1 = i_cfg_data[ldp_pkg::COEF_W-1:0];
                    ldp_pkg::REG_K2:     k2 = i_cfg_data[ldp_pkg::COEF_W-1:0];
                    ldp_pkg::REG_K3:     k3 = i_cfg_data[ldp_pkg::COEF_W-1:0];
                    ldp_pkg::REG_P1:     p1 = i_cfg_data[ldp_pkg::COEF_W-1:0];
                    ldp_pkg::REG_P2:     p2 = i_cfg_data[ldp_pkg::COEF_W-1:0];
                    ldp_pkg::REG_FOCAL: begin
                        fx = i_cfg_data[ldp_pkg::PIXF_W-1:0];
                        fy = i_cfg_data[2*ldp_pkg::PIXF_W-1:ldp_pkg::PIXF_W];
                    end
                    ldp_pkg::REG_CENTER: begin
                        cx = i_cfg_data[ldp_pkg::PIXF_W-1:0];
                        cy = i_cfg_data[2*ldp_pkg::PIXF_W-1:ldp_pkg::PIXF_W];
                    end
                    ldp_pkg::REG_SKEW:   alpha = i_cfg_data[ldp_pkg::SKEW_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= expected_pixels.size();
    end

endmodule

// ----- bench/tb.sv -----
// Testbench top for the lens distortion projector: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY     = 14;
    localparam int WATCHDOG_LIMIT   = 500;
    localparam int RANDOM_PHASES    = 8;
    localparam int POINTS_PER_PHASE = 125;
    localparam int COORD_MAX        = 131071;
    localparam int COORD_MIN        = -131072;
    localparam int COEF_MAX         = 8388607;
    localparam int COEF_MIN         = -8388608;
    localparam int SKEW_MAX         = 2097151;
    localparam int SKEW_MIN         = -2097152;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [ldp_pkg::XW-1:0]     i_x_norm = '0;
    logic signed [ldp_pkg::XW-1:0]     i_y_norm = '0;
    logic                              i_cfg_we = 1'b0;
    logic [ldp_pkg::IDX_W-1:0]         i_cfg_index = '0;
    logic [ldp_pkg::CFG_DW-1:0]        i_cfg_data = '0;
    logic                              o_valid;
    logic signed [ldp_pkg::PIXW-1:0]   o_pixel_x;
    logic signed [ldp_pkg::PIXW-1:0]   o_pixel_y;
    logic                              o_saturated;

    int fail_count, pending, checked, clamped;
    int points_sent = 0;
    int lens_settings = 1;
    int idle_cycles = 0;

    always #1 i_clk = ~i_clk;

    lens_distort_project dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_x_norm    (i_x_norm),
        .i_y_norm    (i_y_norm),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_saturated (o_saturated)
    );

    pixel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_x_norm     (i_x_norm),
        .i_y_norm     (i_y_norm),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (o_valid),
        .i_pixel_x    (o_pixel_x),
        .i_pixel_y    (o_pixel_y),
        .i_saturated  (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_clamped    (clamped)
    );

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [ldp_pkg::CFG_DW-1:0] any_word();
        return ldp_pkg::CFG_DW'({$urandom, $urandom});
    endfunction

    // Place a field value in the low bits and random junk above it
    function automatic logic [ldp_pkg::CFG_DW-1:0] pack_field(longint val, int w);
        logic [ldp_pkg::CFG_DW-1:0] mask;
        mask = (ldp_pkg::CFG_DW'(1) << w) - ldp_pkg::CFG_DW'(1);
        return (any_word() & ~mask) | (ldp_pkg::CFG_DW'(val) & mask);
    endfunction

    function automatic int signed_pick(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic logic [ldp_pkg::CFG_DW-1:0] pair_word(int lo, int hi);
        return {ldp_pkg::PIXF_W'($urandom_range(lo, hi)),
                ldp_pkg::PIXF_W'($urandom_range(lo, hi))};
    endfunction

    // Mostly each coordinate within -1.0 to 1.0, some full range, some at the rails, some zero
    function automatic logic signed [ldp_pkg::XW-1:0] random_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return ldp_pkg::XW'(int'($urandom_range(0, 131072)) - 65536);
            5, 6, 7:       return ldp_pkg::XW'($urandom);
            8:             return $urandom_range(0, 1) ?
                                  ldp_pkg::XW'(COORD_MAX - int'($urandom_range(0, 15))) :
                                  ldp_pkg::XW'(COORD_MIN + int'($urandom_range(0, 15)));
            default:       return '0;
        endcase
    endfunction

    // Hold the point until the block takes it; start is left high
    task automatic drive_point(int x, int y);
        start    <= 1'b1;
        i_x_norm <= ldp_pkg::XW'(x);
        i_y_norm <= ldp_pkg::XW'(y);
        do @(posedge i_clk); while (busy !== 1'b0);
        points_sent++;
    endtask

    // Stop sending and wait until every predicted word has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic put_reg(ldp_pkg::t_reg_idx idx, logic [ldp_pkg::CFG_DW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Write all settings once the pipeline is empty
    task automatic load_lens(logic [ldp_pkg::CFG_DW-1:0] k1, logic [ldp_pkg::CFG_DW-1:0] k2,
                             logic [ldp_pkg::CFG_DW-1:0] k3, logic [ldp_pkg::CFG_DW-1:0] p1,
                             logic [ldp_pkg::CFG_DW-1:0] p2, logic [ldp_pkg::CFG_DW-1:0] focal,
                             logic [ldp_pkg::CFG_DW-1:0] center,
                             logic [ldp_pkg::CFG_DW-1:0] skew);
        drain_results();
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
        put_reg(ldp_pkg::REG_K1, k1);
        put_reg(ldp_pkg::REG_K2, k2);
        put_reg(ldp_pkg::REG_K3, k3);
        put_reg(ldp_pkg::REG_P1, p1);
        put_reg(ldp_pkg::REG_P2, p2);
        put_reg(ldp_pkg::REG_FOCAL, focal);
        put_reg(ldp_pkg::REG_CENTER, center);
        put_reg(ldp_pkg::REG_SKEW, skew);
        i_cfg_we <= 1'b0;
        lens_settings++;
    endtask

    // Either a plausible camera or every register fully random
    task automatic load_random_lens(bit wild);
        if (wild)
            load_lens(any_word(), any_word(), any_word(), any_word(),
                      any_word(), any_word(), any_word(), any_word());
        else
            load_lens(pack_field(signed_pick(524288), ldp_pkg::COEF_W),
                      pack_field(signed_pick(262144), ldp_pkg::COEF_W),
                      pack_field(signed_pick(104858), ldp_pkg::COEF_W),
                      pack_field(signed_pick(10486), ldp_pkg::COEF_W),
                      pack_field(signed_pick(10486), ldp_pkg::COEF_W),
                      pair_word(100 * 256, 3000 * 256),
                      pair_word(0, 4000 * 256),
                      pack_field(signed_pick(20972), ldp_pkg::SKEW_W));
    endtask

    // Random points in bursts of random length with random gaps between them
    task automatic send_points(int count);
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 40);
        for (int n = 0; n < count; n++) begin
            drive_point(random_coord(), random_coord());
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    start <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 40);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings straight out of reset: every point lands on pixel zero
        drive_point(COORD_MAX, COORD_MIN);
        drive_point(COORD_MIN, COORD_MAX);

        // Typical barrel lens, junk above every coefficient field
        load_lens(pack_field(-209715, ldp_pkg::COEF_W), pack_field(52429, ldp_pkg::COEF_W),
                  pack_field(-10486, ldp_pkg::COEF_W), pack_field(1049, ldp_pkg::COEF_W),
                  pack_field(-2097, ldp_pkg::COEF_W),
                  {20'd209920, 20'd204800},
                  {20'd92160, 20'd163840},
                  pack_field(5243, ldp_pkg::SKEW_W));
        drive_point(0, 0);
        drive_point(COORD_MAX, COORD_MAX);
        drive_point(COORD_MIN, COORD_MIN);
        drive_point(COORD_MAX, COORD_MIN);
        drive_point(COORD_MIN, COORD_MAX);
        drive_point(COORD_MAX, 0);
        drive_point(0, COORD_MIN);
        drive_point(1, -1);
        drive_point(-1, 1);
        drive_point(65536, 0);
        drive_point(0, 65536);
        drive_point(-65536, -65536);
        drive_point(32768, -16384);

        // Every coefficient at its positive rail: clamp high
        load_lens(pack_field(COEF_MAX, ldp_pkg::COEF_W), pack_field(COEF_MAX, ldp_pkg::COEF_W),
                  pack_field(COEF_MAX, ldp_pkg::COEF_W), pack_field(COEF_MAX, ldp_pkg::COEF_W),
                  pack_field(COEF_MAX, ldp_pkg::COEF_W), '1, '1,
                  pack_field(SKEW_MAX, ldp_pkg::SKEW_W));
        drive_point(COORD_MAX, COORD_MAX);
        drive_point(COORD_MIN, COORD_MIN);
        drive_point(0, 0);
        drive_point(1, -1);
        drive_point(COORD_MIN, COORD_MAX);

        // Every coefficient at its negative rail, center at zero: clamp low
        load_lens(pack_field(COEF_MIN, ldp_pkg::COEF_W), pack_field(COEF_MIN, ldp_pkg::COEF_W),
                  pack_field(COEF_MIN, ldp_pkg::COEF_W), pack_field(COEF_MIN, ldp_pkg::COEF_W),
                  pack_field(COEF_MIN, ldp_pkg::COEF_W), '1, '0,
                  pack_field(SKEW_MIN, ldp_pkg::SKEW_W));
        drive_point(COORD_MAX, COORD_MAX);
        drive_point(COORD_MIN, COORD_MIN);
        drive_point(0, 0);
        drive_point(-1, 1);
        drive_point(COORD_MAX, COORD_MIN);

        // Random phases; every fourth one uses fully random settings
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_random_lens(phase % 4 == 3);
            if (phase == 2) begin
                // Pause mid-phase until the pipeline is empty
                send_points(POINTS_PER_PHASE / 2);
                drain_results();
                send_points(POINTS_PER_PHASE - POINTS_PER_PHASE / 2);
            end else begin
                send_points(POINTS_PER_PHASE);
            end
        end

        drain_results();
        repeat (PIPE_LATENCY + 6) @(posedge i_clk);

        $display("Run covered %0d points under %0d lens settings, rails and junk bits included.",
                 points_sent, lens_settings);
        $display("%0d pixel words checked, %0d of them clamped to the output range.",
                 checked, clamped);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d failures, %0d predicted words never arrived", fail_count, pending);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
